// ===== rtl/plp_pkg.sv =====
package plp_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_OPS    = 128;
	localparam int DEF_TIME_WIDTH = 32;

	// Field widths fixed by the interface
	localparam int ACTION_W = 3;
	localparam int ID_W     = 7;
	localparam int STAMP_W  = 32;
	localparam int STAT_W   = 32;
	localparam int OPCNT_W  = 8;

	localparam logic [OPCNT_W-1:0] ID_COUNT_RESET = 8'd128;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CALL_START = 3'd0,
		ACT_CALL_END   = 3'd1,
		ACT_INV_START  = 3'd2,
		ACT_INV_END    = 3'd3,
		ACT_READ       = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NOT_ACTIVE   = 2'd1,
		ST_OUT_OF_RANGE = 2'd2
	} status_t;

endpackage

// ===== rtl/per_id_latency_profiler.sv =====
// Per-operation latency profiler.
//
// Input item: start is a one-cycle command; an item (action, op_id, event_time)
// is taken at a rising edge where start is high and busy is low. Start events
// latch a timestamp and the active id; a matching end event bumps that id's
// count and folds the elapsed time into its min/max; a read returns the stats.
// Config: cfg_we/cfg_wdata write the number of ids in use; write only while idle.
//
// Result: done is high for exactly one cycle per item, from the result registers
// behind stage 1, with status and the six statistics of op_id after the event.
// The receiver cannot stall; nothing holds a result back.
//
// Throughput: one item per cycle when not busy. The table is one memory read at
// the accepting edge and written at the end of the next cycle; the entry just
// written is forwarded to the item behind it, so back-to-back hits on the same
// id see fresh data. The per-item path is one TIME_WIDTH subtract and compare.
//
// Reset: arst_n clears control state and the id count goes to 128. The table is
// then swept to zero, one entry per cycle, over all MAX_OPS entries with busy
// high; no item is taken during the sweep, config writes still are.
module per_id_latency_profiler
	import plp_pkg::*;
#(
	parameter int MAX_OPS    = DEF_MAX_OPS,
	parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [ACTION_W-1:0] action,
	input  logic [ID_W-1:0]     op_id,
	input  logic [STAMP_W-1:0]  event_time,
	input  logic                cfg_we,
	input  logic [OPCNT_W-1:0]  cfg_wdata,
	output logic                done,
	output logic [1:0]          status,
	output logic [STAT_W-1:0]   call_count,
	output logic [STAT_W-1:0]   invocation_count,
	output logic [STAT_W-1:0]   call_lat_min,
	output logic [STAT_W-1:0]   call_lat_max,
	output logic [STAT_W-1:0]   inv_lat_min,
	output logic [STAT_W-1:0]   inv_lat_max
);

	localparam int AW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
	localparam int TW = TIME_WIDTH;

	typedef struct packed {
		logic [STAT_W-1:0] calls;
		logic [STAT_W-1:0] invs;
		logic [TW-1:0]     min_c;
		logic [TW-1:0]     max_c;
		logic [TW-1:0]     min_i;
		logic [TW-1:0]     max_i;
	} entry_t;

	entry_t mem [MAX_OPS];

	// Control and architectural state
	logic [OPCNT_W-1:0] id_count_q;
	logic               clr_q;
	logic [AW-1:0]      clr_addr_q;
	logic [ID_W-1:0]    active_id_q;
	logic [TW-1:0]      call_begin_q;
	logic [TW-1:0]      inv_begin_q;

	// Stage 1: the accepted item and its table entry
	logic               valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [ID_W-1:0]    op_id_s1;
	logic [AW-1:0]      addr_s1;
	logic [TW-1:0]      t_s1;
	entry_t             rd_s1;

	// Forward path for the entry written at the last edge
	logic               fwd_vld_q;
	logic [AW-1:0]      fwd_addr_q;
	entry_t             fwd_data_q;

	// Result registers
	logic               done_q;
	status_t            status_q;
	entry_t             res_q;

	logic               accept;
	logic               in_range;
	entry_t             cur;
	entry_t             nxt;
	logic               upd;
	status_t            st;
	logic [ID_W-1:0]    active_id_d;
	logic [TW-1:0]      call_begin_d;
	logic [TW-1:0]      inv_begin_d;
	logic [TW-1:0]      d_call;
	logic [TW-1:0]      d_inv;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	entry_t             mem_wd;

	assign busy   = clr_q;
	assign accept = start && !busy;

	// Config register and the post-reset table sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_count_q <= ID_COUNT_RESET;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (cfg_we) begin
				id_count_q <= cfg_wdata;
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(MAX_OPS - 1)) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	// Capture the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			op_id_s1  <= op_id;
			addr_s1   <= AW'(op_id);
			t_s1      <= TW'(event_time);
		end
	end

	// Table read, registered
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[AW'(op_id)];
		end
	end

	// Table write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// Use the forwarded entry when the previous item just wrote this id
	assign cur = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_s1;

	assign in_range = ({1'b0, op_id_s1} < {1'b0, id_count_q})
		&& (32'(op_id_s1) < 32'(MAX_OPS));

	assign d_call = t_s1 - call_begin_q;
	assign d_inv  = t_s1 - inv_begin_q;

	always_comb begin
		nxt          = cur;
		upd          = 1'b0;
		st           = ST_OK;
		active_id_d  = active_id_q;
		call_begin_d = call_begin_q;
		inv_begin_d  = inv_begin_q;
		if (!in_range) begin
			st = ST_OUT_OF_RANGE;
		end else begin
			unique case (action_s1)
				ACT_CALL_START: begin
					call_begin_d = t_s1;
					active_id_d  = op_id_s1;
				end
				ACT_CALL_END: begin
					if (op_id_s1 != active_id_q) begin
						st = ST_NOT_ACTIVE;
					end else begin
						upd       = 1'b1;
						nxt.calls = cur.calls + 1'b1;
						if (d_call < cur.min_c || cur.min_c == '0) begin
							nxt.min_c = d_call;
						end
						if (d_call > cur.max_c) begin
							nxt.max_c = d_call;
						end
					end
				end
				ACT_INV_START: begin
					inv_begin_d = t_s1;
					active_id_d = op_id_s1;
				end
				ACT_INV_END: begin
					if (op_id_s1 != active_id_q) begin
						st = ST_NOT_ACTIVE;
					end else begin
						upd      = 1'b1;
						nxt.invs = cur.invs + 1'b1;
						if (d_inv < cur.min_i || cur.min_i == '0) begin
							nxt.min_i = d_inv;
						end
						if (d_inv > cur.max_i) begin
							nxt.max_i = d_inv;
						end
					end
				end
				default: begin
					// read, and any unused code
				end
			endcase
		end
	end

	// The sweep owns the write port until it ends; no item is in flight then
	assign mem_we = clr_q || (valid_s1 && upd);
	assign mem_wa = clr_q ? clr_addr_q : addr_s1;
	assign mem_wd = clr_q ? entry_t'('0) : nxt;

	// Advance the latched id and begin times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_id_q  <= '0;
			call_begin_q <= '0;
			inv_begin_q  <= '0;
			fwd_vld_q    <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			if (valid_s1) begin
				active_id_q  <= active_id_d;
				call_begin_q <= call_begin_d;
				inv_begin_q  <= inv_begin_d;
			end
			fwd_vld_q <= valid_s1 && upd;
			done_q    <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= nxt;
		if (valid_s1) begin
			status_q <= st;
			res_q    <= in_range ? nxt : entry_t'('0);
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign call_count       = res_q.calls;
	assign invocation_count = res_q.invs;
	assign call_lat_min     = STAT_W'(res_q.min_c);
	assign call_lat_max     = STAT_W'(res_q.max_c);
	assign inv_lat_min      = STAT_W'(res_q.min_i);
	assign inv_lat_max      = STAT_W'(res_q.max_i);

endmodule

// ===== rtl/plp_checker.sv =====
module plp_checker
	import plp_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [1:0]          status,
	input logic [STAT_W-1:0]   call_count,
	input logic [STAT_W-1:0]   invocation_count,
	input logic [STAT_W-1:0]   call_lat_min,
	input logic [STAT_W-1:0]   call_lat_max,
	input logic [STAT_W-1:0]   inv_lat_min,
	input logic [STAT_W-1:0]   inv_lat_max
);

	// Every taken item yields a result on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("taken item produced no result");

	// No result without a taken item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##2 !done)
		else $error("result without a taken item");

	// An out-of-range id reports all-zero statistics
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OUT_OF_RANGE) |->
		(call_count == '0 && invocation_count == '0 && call_lat_min == '0
		&& call_lat_max == '0 && inv_lat_min == '0
		&& inv_lat_max == '0))
		else $error("out-of-range result carries statistics");

	// The clearing sweep runs once after reset and never restarts
	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose outside reset");

endmodule

bind per_id_latency_profiler plp_checker u_plp_checker (.*);

// ===== verif/tb_per_id_latency_profiler.sv =====
`timescale 1ns / 100ps

module tb_per_id_latency_profiler;
	import plp_pkg::*;

	localparam int TABLE_DEPTH  = DEF_MAX_OPS;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PRINT_LIMIT  = 100;
	localparam int NUM_FIELDS   = 7;

	// One profiling event as it goes onto the input ports
	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [ID_W-1:0]     id;
		logic [STAMP_W-1:0]  stamp;
	} prof_event_t;

	// Statistics reported for one event
	typedef struct packed {
		status_t           status;
		logic [STAT_W-1:0] calls;
		logic [STAT_W-1:0] invs;
		logic [STAT_W-1:0] min_call;
		logic [STAT_W-1:0] max_call;
		logic [STAT_W-1:0] min_inv;
		logic [STAT_W-1:0] max_inv;
	} op_stats_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [ACTION_W-1:0] action = '0;
	logic [ID_W-1:0]     op_id = '0;
	logic [STAMP_W-1:0]  event_time = '0;
	logic                cfg_we = 1'b0;
	logic [OPCNT_W-1:0]  cfg_wdata = '0;
	logic                busy;
	logic                done;
	logic [1:0]          status;
	logic [STAT_W-1:0]   call_count;
	logic [STAT_W-1:0]   invocation_count;
	logic [STAT_W-1:0]   call_lat_min;
	logic [STAT_W-1:0]   call_lat_max;
	logic [STAT_W-1:0]   inv_lat_min;
	logic [STAT_W-1:0]   inv_lat_max;

	per_id_latency_profiler u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.action           (action),
		.op_id            (op_id),
		.event_time       (event_time),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.done             (done),
		.status           (status),
		.call_count       (call_count),
		.invocation_count (invocation_count),
		.call_lat_min     (call_lat_min),
		.call_lat_max     (call_lat_max),
		.inv_lat_min      (inv_lat_min),
		.inv_lat_max      (inv_lat_max)
	);

	// Shadow copy of the block's statistics and latched state
	logic [STAT_W-1:0]  call_cnt_tbl [TABLE_DEPTH];
	logic [STAT_W-1:0]  inv_cnt_tbl  [TABLE_DEPTH];
	logic [STAT_W-1:0]  min_call_tbl [TABLE_DEPTH];
	logic [STAT_W-1:0]  max_call_tbl [TABLE_DEPTH];
	logic [STAT_W-1:0]  min_inv_tbl  [TABLE_DEPTH];
	logic [STAT_W-1:0]  max_inv_tbl  [TABLE_DEPTH];
	logic [ID_W-1:0]    cur_id = '0;
	logic [STAMP_W-1:0] call_t0 = '0;
	logic [STAMP_W-1:0] inv_t0 = '0;
	logic [OPCNT_W-1:0] ops_in_use = ID_COUNT_RESET;

	prof_event_t event_queue [$];
	op_stats_t   stats_due [$];

	int          err_count = 0;
	int          cycle_count = 0;
	int          queued_total = 0;
	int          idle_pct = 0;
	int          gen_ops = ID_COUNT_RESET;
	logic        taken_q = 1'b0;

	string field_name [NUM_FIELDS] = '{"status", "call_count", "invocation_count",
		"call_lat_min", "call_lat_max", "inv_lat_min", "inv_lat_max"};

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			call_cnt_tbl[i] = '0;
			inv_cnt_tbl[i]  = '0;
			min_call_tbl[i] = '0;
			max_call_tbl[i] = '0;
			min_inv_tbl[i]  = '0;
			max_inv_tbl[i]  = '0;
		end
	end

	initial begin
		forever #5 clk = ~clk;
	end

	// Print one line per mismatch (up to a cap) and count every one
	task automatic report_mismatch(input string msg);
		if (err_count < PRINT_LIMIT)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_count++;
	endtask

	// Fold one duration into a min/max pair; an empty minimum is zero
	function automatic void fold_span(ref logic [STAT_W-1:0] mn, ref logic [STAT_W-1:0] mx,
			input logic [STAMP_W-1:0] span);
		if (span < mn || mn == '0)
			mn = span;
		if (span > mx)
			mx = span;
	endfunction

	// Apply one event to the shadow state and return the statistics it reports
	function automatic op_stats_t profile_event(input prof_event_t ev);
		op_stats_t res;
		int        id_limit;

		id_limit = (int'(ops_in_use) < TABLE_DEPTH) ? int'(ops_in_use) : TABLE_DEPTH;
		res = '0;
		if (int'(ev.id) >= id_limit) begin
			res.status = ST_OUT_OF_RANGE;
			return res;
		end
		res.status = ST_OK;
		case (ev.act)
			ACT_CALL_START: begin
				call_t0 = ev.stamp;
				cur_id  = ev.id;
			end
			ACT_CALL_END: begin
				if (ev.id != cur_id) begin
					res.status = ST_NOT_ACTIVE;
				end else begin
					call_cnt_tbl[ev.id] = call_cnt_tbl[ev.id] + 1'b1;
					fold_span(min_call_tbl[ev.id], max_call_tbl[ev.id], ev.stamp - call_t0);
				end
			end
			ACT_INV_START: begin
				cur_id = ev.id;
				inv_t0 = ev.stamp;
			end
			ACT_INV_END: begin
				if (ev.id != cur_id) begin
					res.status = ST_NOT_ACTIVE;
				end else begin
					inv_cnt_tbl[ev.id] = inv_cnt_tbl[ev.id] + 1'b1;
					fold_span(min_inv_tbl[ev.id], max_inv_tbl[ev.id], ev.stamp - inv_t0);
				end
			end
			default: ;	// reads and unknown actions leave the state alone
		endcase
		res.calls    = call_cnt_tbl[ev.id];
		res.invs     = inv_cnt_tbl[ev.id];
		res.min_call = min_call_tbl[ev.id];
		res.max_call = max_call_tbl[ev.id];
		res.min_inv  = min_inv_tbl[ev.id];
		res.max_inv  = max_inv_tbl[ev.id];
		return res;
	endfunction

	// Driver: present the next item at the falling edge, hold it until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && !taken_q)) begin
			if (event_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				prof_event_t ev;
				ev = event_queue.pop_front();
				start      <= 1'b1;
				action     <= ev.act;
				op_id      <= ev.id;
				event_time <= ev.stamp;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check the result due this cycle, then predict for the item taken now
	always @(posedge clk) begin
		op_stats_t         want;
		logic [STAT_W-1:0] got_f [NUM_FIELDS];
		logic [STAT_W-1:0] want_f [NUM_FIELDS];

		if (arst_n) begin
			if (done) begin
				if (stats_due.size() == 0) begin
					report_mismatch("result strobe with no item outstanding");
				end else begin
					want = stats_due.pop_front();
					got_f[0]  = STAT_W'(status);
					got_f[1]  = call_count;
					got_f[2]  = invocation_count;
					got_f[3]  = call_lat_min;
					got_f[4]  = call_lat_max;
					got_f[5]  = inv_lat_min;
					got_f[6]  = inv_lat_max;
					want_f[0] = STAT_W'(want.status);
					want_f[1] = want.calls;
					want_f[2] = want.invs;
					want_f[3] = want.min_call;
					want_f[4] = want.max_call;
					want_f[5] = want.min_inv;
					want_f[6] = want.max_inv;
					for (int f = 0; f < NUM_FIELDS; f++) begin
						if (got_f[f] !== want_f[f])
							report_mismatch($sformatf("%s got 0x%08h want 0x%08h",
								field_name[f], got_f[f], want_f[f]));
					end
				end
			end
			if (cfg_we)
				ops_in_use = cfg_wdata;
			if (start && !busy)
				stats_due.push_back(profile_event('{action, op_id, event_time}));
		end
		taken_q <= arst_n && start && !busy;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_event(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id,
			input logic [STAMP_W-1:0] stamp);
		event_queue.push_back('{act, id, stamp});
		queued_total++;
	endtask

	// Favor a few low ids so statistics build up; stray out of range now and then
	function automatic logic [ID_W-1:0] pick_id();
		int eff;
		int r;
		int hot;

		eff = (gen_ops < TABLE_DEPTH) ? gen_ops : TABLE_DEPTH;
		r   = $urandom_range(0, 99);
		hot = (eff < 6) ? eff : 6;
		if (eff == 0)
			return ID_W'($urandom_range(0, TABLE_DEPTH - 1));
		if (eff < TABLE_DEPTH && r < 12)
			return ID_W'($urandom_range(eff, TABLE_DEPTH - 1));
		if (r < 60)
			return ID_W'($urandom_range(0, hot - 1));
		return ID_W'($urandom_range(0, eff - 1));
	endfunction

	// Duration between a start and its end: zero, short, near-full or anything
	function automatic logic [STAMP_W-1:0] pick_span();
		int r;

		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return STAMP_W'($urandom);
		if (r < 25)
			return '1 - STAMP_W'($urandom_range(0, 100));
		return STAMP_W'($urandom_range(1, 5000));
	endfunction

	task automatic write_id_count(input logic [OPCNT_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		gen_ops    = int'(value);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Edge cases, run with all ids enabled
	task automatic queue_directed();
		push_event(ACT_READ, 7'd0, '0);
		push_event(ACT_READ, 7'd127, '1);
		// elapsed time wraps through zero
		push_event(ACT_CALL_START, 7'd127, 32'hFFFF_FFF0);
		push_event(ACT_CALL_END, 7'd127, 32'h0000_0010);
		// end for an id that is not the active one
		push_event(ACT_CALL_END, 7'd5, 32'h0000_0100);
		// zero duration on an empty entry
		push_event(ACT_CALL_START, 7'd0, '0);
		push_event(ACT_CALL_END, 7'd0, '0);
		push_event(ACT_CALL_START, 7'd0, 32'd100);
		push_event(ACT_CALL_END, 7'd0, 32'd300);
		// zero duration once a minimum exists
		push_event(ACT_CALL_START, 7'd0, 32'h5555_5555);
		push_event(ACT_CALL_END, 7'd0, 32'h5555_5555);
		// largest possible duration
		push_event(ACT_CALL_START, 7'd0, '0);
		push_event(ACT_CALL_END, 7'd0, '1);
		push_event(ACT_INV_START, 7'd3, '1);
		push_event(ACT_INV_END, 7'd3, 32'hFFFF_FFFE);
		push_event(ACT_INV_START, 7'd3, 32'd1000);
		push_event(ACT_INV_END, 7'd3, 32'd1001);
		push_event(ACT_INV_END, 7'd4, 32'hAAAA_AAAA);
		// unknown actions act as reads
		push_event(ACT_READ + 3'd1, 7'd3, 32'h1234_5678);
		push_event(ACT_READ + 3'd2, 7'd3, 32'h8765_4321);
		push_event(ACT_READ + 3'd3, 7'd127, 32'hDEAD_BEEF);
		push_event(ACT_READ, 7'd3, '0);
		push_event(ACT_READ, 7'd127, '0);
		push_event(ACT_READ, 7'd0, '0);
	endtask

	// Mostly matched start/end pairs with random content, the rest noise
	task automatic queue_random_events(input int count);
		int                 base;
		int                 r;
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] t0;
		logic [STAMP_W-1:0] t1;
		logic               is_call;

		base = queued_total;
		while (queued_total - base < count) begin
			r  = $urandom_range(0, 99);
			id = pick_id();
			t0 = STAMP_W'($urandom);
			if (r < 70) begin
				is_call = (r < 40);
				push_event(is_call ? ACT_CALL_START : ACT_INV_START, id, t0);
				if ($urandom_range(0, 3) == 0)
					push_event(ACT_READ, pick_id(), STAMP_W'($urandom));
				push_event(is_call ? ACT_CALL_END : ACT_INV_END, id, t0 + pick_span());
			end else if (r < 80) begin
				// call nested in an invocation of the same id
				t1 = t0 + STAMP_W'($urandom_range(0, 50));
				push_event(ACT_INV_START, id, t0);
				push_event(ACT_CALL_START, id, t1);
				push_event(ACT_CALL_END, id, t1 + pick_span());
				push_event(ACT_INV_END, id, t0 + pick_span());
			end else if (r < 88) begin
				push_event(ACT_READ, id, t0);
			end else if (r < 95) begin
				// dangling end, likely for the wrong id
				push_event($urandom_range(0, 1) ? ACT_CALL_END : ACT_INV_END, id, t0);
			end else if (r < 98) begin
				push_event(ACT_READ + ACTION_W'($urandom_range(1, 3)), id, t0);
			end else begin
				push_event($urandom_range(0, 1) ? ACT_CALL_START : ACT_INV_START, id, t0);
			end
		end
	endtask

	// Wait for the driver to run dry and all results to arrive
	task automatic drain();
		int waited;

		do @(posedge clk); while (event_queue.size() != 0 || start);
		waited = 0;
		while (stats_due.size() != 0 && waited < 16) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int idle_plan [3];
		int phase_len [6];
		int phase_ops [6];

		idle_plan = '{22, 47, 0};
		phase_len = '{60, 20, 110, 110, 110, 120};
		phase_ops = '{1, 0, 255, $urandom_range(2, 127), 128, 9};

		// Hold reset, then release on a falling edge
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		write_id_count(ID_COUNT_RESET);
		idle_pct = idle_plan[0];
		queue_directed();
		queue_random_events(90);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_id_count(OPCNT_W'(phase_ops[ph]));
			idle_pct = idle_plan[(ph + 1) % 3];
			queue_random_events(phase_len[ph]);
			drain();
		end

		if (stats_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", stats_due.size()));

		if (err_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/plp_pkg.sv
rtl/per_id_latency_profiler.sv
rtl/plp_checker.sv
verif/tb_per_id_latency_profiler.sv
